>>> design/utf8_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared property wrappers for the checker on the decoder's ports.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define U8SD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define U8SD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> design/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types, status codes and lead byte decoding.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int CP_W    = 31;
    localparam int NEED_W  = 3;
    localparam int LEAD_W  = 5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STRAY = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      status;
    } result_t;

    typedef struct packed {
        logic [NEED_W-1:0] need;
        logic [LEAD_W-1:0] bits;
    } lead_t;

    // Count of following bytes and payload bits of a multi-byte lead byte.
    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t l;
        priority if (!b[5]) begin
            l.need = 3'd1; l.bits = b[4:0];
        end else if (!b[4]) begin
            l.need = 3'd2; l.bits = {1'b0, b[3:0]};
        end else if (!b[3]) begin
            l.need = 3'd3; l.bits = {2'b0, b[2:0]};
        end else if (!b[2]) begin
            l.need = 3'd4; l.bits = {3'b0, b[1:0]};
        end else begin
            l.need = 3'd5; l.bits = {4'b0, b[0]};
        end
        return l;
    endfunction

endpackage

>>> design/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream in the original six-byte UTF-8 form into code points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one text byte per request, with
//   s_end_of_text marking the last byte of a text.
//   Result channel (m_valid/m_ready): one request per completed character,
//   stray continuation byte (status 1) or truncated text (status 2). Error
//   results carry a zero code point. Bytes that open or continue a sequence
//   without finishing it give no result.
//   Path: a result's last byte passes the input register, then the result
//   register.
//   Throughput: one byte per cycle while the receiver keeps m_ready high;
//   the decode is a single pass of shift-and-merge logic on the held byte.
//   Stall: while a result waits, hold the byte in the input register,
//   whether or not it gives a result; the input register takes one more
//   byte and then fills. s_ready falls only when both registers are full
//   and m_ready is low.
//   Reset: aresetn (synchronous, active low) empties both registers and
//   drops any open sequence.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_code_point,
    output logic [1:0]  m_status
);
    import u8sd_pkg::*;

    item_t   item_in, item_held;
    result_t res, res_out;
    logic    held, advance, res_valid, s_fire;

    assign item_in.data_byte   = s_data_byte;
    assign item_in.end_of_text = s_end_of_text;

    // advance the held byte when the result register is free or draining
    assign advance = held && (!m_valid || m_ready);
    assign s_ready = !held || advance;
    assign s_fire  = s_valid && s_ready;

    u8sd_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_fire),
        .item_in  (item_in),
        .take     (advance),
        .full     (held),
        .item_out (item_held)
    );

    u8sd_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item_held),
        .res_valid (res_valid),
        .res       (res)
    );

    // capture a result only when the step produces one
    u8sd_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res_in  (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .res_out (res_out)
    );

    assign m_code_point = res_out.code_point;
    assign m_status     = res_out.status;

endmodule

>>> design/u8sd_in_reg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder input register
// Holds one accepted byte until the decode step takes it.
// ----------------------------------------------------------------------------
module u8sd_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  u8sd_pkg::item_t item_in,
    input  logic           take,
    output logic           full,
    output u8sd_pkg::item_t item_out
);
    import u8sd_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    assign full     = valid_reg;
    assign item_out = item_reg;

endmodule

>>> design/u8sd_step.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder step
// Sequence state and the per-byte decode, one byte per cycle while advance is high.
// ----------------------------------------------------------------------------
module u8sd_step (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  u8sd_pkg::item_t  item,
    output logic             res_valid,
    output u8sd_pkg::result_t res
);
    import u8sd_pkg::*;

    logic [CP_W-1:0]   partial_reg, partial_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [CP_W-1:0]   shifted;
    logic [NEED_W-1:0] need_dec;
    lead_t             lead;

    assign shifted  = {partial_reg[CP_W-7:0], item.data_byte[5:0]};
    assign need_dec = need_reg - 3'd1;
    assign lead     = lead_decode(item.data_byte);

    always_comb begin
        partial_next   = partial_reg;
        need_next      = need_reg;
        res_valid      = 1'b0;
        res.code_point = '0;
        res.status     = ST_OK;
        if (need_reg == '0) begin
            priority if (!item.data_byte[7]) begin
                res_valid      = 1'b1;
                res.code_point = {{(CP_W-8){1'b0}}, item.data_byte};
            end else if (!item.data_byte[6]) begin
                res_valid  = 1'b1;
                res.status = ST_STRAY;
            end else if (item.end_of_text) begin
                res_valid    = 1'b1;
                res.status   = ST_TRUNC;
                partial_next = '0;
            end else begin
                partial_next = {{(CP_W-LEAD_W){1'b0}}, lead.bits};
                need_next    = lead.need;
            end
        end else begin
            priority if (need_dec == '0) begin
                res_valid      = 1'b1;
                res.code_point = shifted;
                partial_next   = '0;
                need_next      = '0;
            end else if (item.end_of_text) begin
                res_valid    = 1'b1;
                res.status   = ST_TRUNC;
                partial_next = '0;
                need_next    = '0;
            end else begin
                partial_next = shifted;
                need_next    = need_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            need_reg    <= '0;
        end else if (advance) begin
            partial_reg <= partial_next;
            need_reg    <= need_next;
        end
    end

endmodule

>>> design/u8sd_out_reg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module u8sd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  u8sd_pkg::result_t res_in,
    input  logic              m_ready,
    output logic              m_valid,
    output u8sd_pkg::result_t res_out
);
    import u8sd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

>>> design/u8sd_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level checks on the decoder, attached by bind.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_assert.svh"

module u8sd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [30:0] m_code_point,
    input logic [1:0]  m_status
);
    import u8sd_pkg::*;

    // hold a stalled result
    `U8SD_ASSERT(a_stall_hold, m_valid && !m_ready |=> m_valid && $stable(m_code_point) && $stable(m_status), "stalled result changed")
    // error results carry no code point
    `U8SD_ASSERT(a_err_zero, m_valid && (m_status == ST_STRAY || m_status == ST_TRUNC) |-> m_code_point == '0, "error result with nonzero code point")
    // input backpressure only from a stalled result
    `U8SD_ASSERT(a_bp_cause, !s_ready |-> m_valid && !m_ready, "input stalled without a waiting result")
    // reset empties the block
    `U8SD_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid && s_ready, "not empty after reset")

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Sends text bytes through the input channel and checks each decoded
// character or error against an in-bench prediction of the decoder.
// ----------------------------------------------------------------------------
module testbench;
    import u8sd_pkg::*;

    localparam int HOLD_CYCLES  = 150;  // long receiver hold-off for the pressure test
    localparam int STALL_LIMIT  = 1000; // cycles with no request moving before giving up
    localparam int RANDOM_BYTES = 128;  // bytes per random phase

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_end_of_text;
    logic        m_valid;
    logic        m_ready;
    logic [30:0] m_code_point;
    logic [1:0]  m_status;

    // Decoder state as predicted by the bench
    logic [30:0] partial_cp;
    logic [2:0]  owed_bytes;

    // Characters and errors still to come out of the block, oldest first
    result_t expected_chars[$];

    int  fail_count;
    int  bytes_sent;
    int  idle_cycles;
    bit  tx_idle_on;
    bit  rx_idle_on;
    bit  hold_req;

    utf8_stream_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_status      (m_status)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Work out what one accepted byte gives; return 1 when it gives a result.
    function automatic bit decode_byte(input logic [7:0] b, input logic eot,
                                       output result_t r);
        logic [2:0]  need;
        logic [30:0] bits;
        r.code_point = '0;
        r.status     = ST_OK;
        if (owed_bytes == 3'd0) begin
            // Plain ASCII stands alone
            if (!b[7]) begin
                r.code_point = {23'd0, b};
                return 1'b1;
            end
            // Continuation byte with no open sequence
            if (b[7:6] == 2'b10) begin
                r.status = ST_STRAY;
                return 1'b1;
            end
            // Lead byte: the run of ones sets the length, 0xFE/0xFF fold into six bytes
            casez (b)
                8'b110?????: begin need = 3'd1; bits = 31'(b[4:0]); end
                8'b1110????: begin need = 3'd2; bits = 31'(b[3:0]); end
                8'b11110???: begin need = 3'd3; bits = 31'(b[2:0]); end
                8'b111110??: begin need = 3'd4; bits = 31'(b[1:0]); end
                default:     begin need = 3'd5; bits = 31'(b[0]);   end
            endcase
            if (eot) begin
                partial_cp = '0;
                r.status   = ST_TRUNC;
                return 1'b1;
            end
            partial_cp = bits;
            owed_bytes = need;
            return 1'b0;
        end
        // Following byte: merge six bits, no check on the top two
        partial_cp = {partial_cp[24:0], b[5:0]};
        owed_bytes = owed_bytes - 3'd1;
        if (owed_bytes == 3'd0) begin
            r.code_point = partial_cp;
            partial_cp   = '0;
            return 1'b1;
        end
        if (eot) begin
            partial_cp = '0;
            owed_bytes = '0;
            r.status   = ST_TRUNC;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Random lead byte for a sequence of len bytes in all
    function automatic logic [7:0] lead_for(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            4:       return {5'b11110, 3'($urandom)};
            5:       return {6'b111110, 2'($urandom)};
            default: return {6'b111111, 2'($urandom)};
        endcase
    endfunction

    // Offer one byte, hold it until accepted, then predict and maybe idle.
    // Leave s_valid high when no gap follows so back-to-back requests flow.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        result_t r;
        int      gap;
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (decode_byte(b, eot, r))
            expected_chars.push_back(r);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop the request after the last byte of a test
    task automatic end_requests();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Extremes of single bytes: ASCII ends and stray continuation ends
    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b1);
        end_requests();
    endtask

    // Shortest and longest sequences, unchecked following bytes, end flag cases
    task automatic test_sequences();
        // Smallest two-byte form
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        // Six bytes from 0xFF, largest code point
        send_byte(8'hFF, 1'b0);
        repeat (5) send_byte(8'hBF, 1'b0);
        // Following byte that is not 10xxxxxx is merged anyway
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // End flag on the completing byte gives the character
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b1);
        end_requests();
    endtask

    // Text ending on a lead byte and in the middle of a sequence
    task automatic test_truncation();
        send_byte(8'hF0, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b1);
        end_requests();
    endtask

    // Hold the receiver off and keep offering bytes so that the input stalls
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        repeat (24) send_byte(8'(8'h20 + $urandom_range(0, 90)), 1'b0);
        end_requests();
    endtask

    // One random character, error or broken sequence
    task automatic send_random_char();
        int         kind;
        int         len;
        int         cut;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 9) == 0);
        end else if (kind < 75) begin
            // Well-formed sequence with random payload
            len = $urandom_range(2, 6);
            send_byte(lead_for(len), 1'b0);
            for (int i = 1; i < len; i++)
                send_byte({2'b10, 6'($urandom)}, (i == len - 1) && ($urandom_range(0, 9) == 0));
        end else if (kind < 85) begin
            // Following bytes of any value
            len = $urandom_range(2, 6);
            send_byte(lead_for(len), 1'b0);
            for (int i = 1; i < len; i++)
                send_byte(8'($urandom), 1'b0);
        end else if (kind < 93) begin
            send_byte({2'b10, 6'($urandom)}, 1'($urandom_range(0, 1)));
        end else begin
            // Text cut short inside a sequence
            len = $urandom_range(2, 6);
            cut = $urandom_range(1, len - 1);
            b   = lead_for(len);
            send_byte(b, cut == 1);
            for (int i = 1; i < cut; i++)
                send_byte({2'b10, 6'($urandom)}, i == cut - 1);
        end
    endtask

    // Random text in four phases covering each mix of idling on both sides
    task automatic test_random_text();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            tx_idle_on = (phase == 0) || (phase == 2);
            rx_idle_on = (phase == 0) || (phase == 3);
            target     = bytes_sent + RANDOM_BYTES;
            while (bytes_sent < target)
                send_random_char();
        end
        end_requests();
    endtask

    // Receiver: random gaps, stretches without them, and the long hold-off
    initial begin : receiver
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                gap = rx_idle_on ? pick_gap() : 0;
                if (gap == 0) begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected result: code_point %h status %0d", m_code_point, m_status);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (m_code_point !== want.code_point) begin
                    $error("code_point mismatch: expected %h, got %h",
                           want.code_point, m_code_point);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    // Stop the run if no request moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data_byte   <= 8'h00;
        s_end_of_text <= 1'b0;
        partial_cp  = '0;
        owed_bytes  = '0;
        fail_count  = 0;
        bytes_sent  = 0;
        idle_cycles = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_req    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_bytes();
        test_sequences();
        test_truncation();
        test_backpressure();
        test_random_text();

        // Drain, then allow the two-stage latency for anything left over
        while (expected_chars.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
